>>> src/pfg_pkg.sv
// ----------------------------------------------------------------------------
// pfg_pkg
// Types, widths and register codes shared by the frequency governor files.
// ----------------------------------------------------------------------------
`default_nettype none

package pfg_pkg;

  localparam int KhzW   = 19;
  localparam int IntenW = 11;
  localparam int TempW  = 12;
  localparam int DurW   = 16;
  localparam int TimeW  = 32;
  localparam int CntW   = 32;
  localparam int AddrW  = 5;
  localparam int DataW  = 32;

  // default tuning, overridable on the top level
  localparam int DefMaxFreqKhz = 250000;
  localparam int DefMedStepKhz = 230000;
  localparam int DefDurHighMs  = 500;
  localparam int DefDurMedMs   = 250;
  localparam int DefDurShortMs = 200;

  // moderate load goes idle at or below 40 percent
  localparam logic [IntenW-1:0] ModerateIdleInten = IntenW'(640);

  // register indexes
  localparam logic [2:0] RegCooldown  = 3'd0;
  localparam logic [2:0] RegHighInten = 3'd1;
  localparam logic [2:0] RegMedInten  = 3'd2;
  localparam logic [2:0] RegLowInten  = 3'd3;
  localparam logic [2:0] RegHotLimit  = 3'd4;
  localparam logic [2:0] RegCoolLimit = 3'd5;
  localparam logic [2:0] RegBackoff   = 3'd6;
  localparam logic [2:0] RegIdle      = 3'd7;

  typedef struct packed {
    logic [TimeW-1:0]        now_ms;
    logic [15:0]             sample_count;
    logic [IntenW-1:0]       load_level;
    logic [DurW-1:0]         avg_duration;
    logic signed [TempW-1:0] temperature;
    logic [KhzW-1:0]         running_khz;
  } tick_t;

  typedef struct packed {
    logic [KhzW-1:0]  goal_khz;
    logic             ramp_request;
    logic [CntW-1:0]  adjust_total;
    logic [CntW-1:0]  idle_switch_total;
    logic [KhzW-1:0]  last_set_khz;
    logic [TimeW-1:0] last_adjust_time;
    logic [TimeW-1:0] last_idle_time;
  } result_t;

endpackage

`default_nettype wire

>>> src/perf_frequency_governor_unit.sv
// ----------------------------------------------------------------------------
// perf_frequency_governor_unit
// Clock governor: picks a target clock per tick from workload tiers and
// applies a thermal backoff and restore with hysteresis.
// ----------------------------------------------------------------------------
// Usage:
//   Ticks enter on tick/tick_valid/tick_stall; each accepted item yields one
//   result item on result/result_valid/result_stall carrying the new target,
//   a ramp request and the adjustment statistics.
//   An item is registered on acceptance and evaluated in the input register;
//   as it leaves, the governor state is updated and the result register is
//   loaded. One item can be accepted every cycle while the receiver does not stall.
//   The state loop (target, stamps, counters) is closed once per item and sets that rate.
//   When the receiver stalls, the result register holds and the input
//   register fills; tick_stall rises once both are occupied.
//   Reset (rst, synchronous) empties both stages, restores the register
//   defaults, sets the target to MAX_FREQ_KHZ and clears the statistics.
//   The user must write tuning registers through the APB port only while no
//   item is in flight; the block does not enforce this. Reads return the stored value zero-extended.
// ----------------------------------------------------------------------------
`default_nettype none

module perf_frequency_governor_unit #(
  parameter int MAX_FREQ_KHZ = pfg_pkg::DefMaxFreqKhz,
  parameter int MED_STEP_KHZ = pfg_pkg::DefMedStepKhz,
  parameter int LONG_RUN_MS  = pfg_pkg::DefDurHighMs,
  parameter int MED_RUN_MS   = pfg_pkg::DefDurMedMs,
  parameter int SHORT_RUN_MS = pfg_pkg::DefDurShortMs
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [pfg_pkg::AddrW-1:0] paddr,
  input  wire logic [pfg_pkg::DataW-1:0] pwdata,
  output logic [pfg_pkg::DataW-1:0]    prdata,
  output logic                         pready,
  input  wire logic                    tick_valid,
  output logic                         tick_stall,
  input  wire pfg_pkg::tick_t          tick,
  output logic                         result_valid,
  input  wire logic                    result_stall,
  output pfg_pkg::result_t             result
);
  import pfg_pkg::*;

  localparam logic [KhzW-1:0] MaxKhz = KhzW'(MAX_FREQ_KHZ);
  localparam logic [KhzW-1:0] MedKhz =
    (MAX_FREQ_KHZ > MED_STEP_KHZ) ? KhzW'(MED_STEP_KHZ) : KhzW'(MAX_FREQ_KHZ);
  localparam logic [DurW-1:0] DurHigh  = DurW'(LONG_RUN_MS);
  localparam logic [DurW-1:0] DurMed   = DurW'(MED_RUN_MS);
  localparam logic [DurW-1:0] DurShort = DurW'(SHORT_RUN_MS);

  // tuning registers
  logic [15:0]             hold_off;
  logic [IntenW-1:0]       high_intensity_thr;
  logic [IntenW-1:0]       med_intensity_thr;
  logic [IntenW-1:0]       low_intensity_thr;
  logic signed [TempW-1:0] hot_limit;
  logic signed [TempW-1:0] cool_limit;
  logic [KhzW-1:0]         backoff_khz;
  logic [KhzW-1:0]         idle_khz;

  // governor state
  logic [KhzW-1:0]  target_freq, target_freq_next;
  logic [TimeW-1:0] adjust_stamp, adjust_stamp_next;
  logic [KhzW-1:0]  recorded_target, recorded_target_next;
  logic [CntW-1:0]  adjust_counter, adjust_counter_next;
  logic [CntW-1:0]  idle_counter, idle_counter_next;
  logic [TimeW-1:0] idle_stamp, idle_stamp_next;

  // pipeline
  logic  s1_valid;
  tick_t s1;
  logic  advance;
  logic  cfg_write;
  logic [2:0] reg_index;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign reg_index = paddr[AddrW-1:2];

  assign advance    = !result_valid || !result_stall;
  assign tick_stall = s1_valid && !advance;

  always_comb begin
    unique case (reg_index)
      RegCooldown:  prdata = DataW'(hold_off);
      RegHighInten: prdata = DataW'(high_intensity_thr);
      RegMedInten:  prdata = DataW'(med_intensity_thr);
      RegLowInten:  prdata = DataW'(low_intensity_thr);
      RegHotLimit:  prdata = DataW'($unsigned(hot_limit));
      RegCoolLimit: prdata = DataW'($unsigned(cool_limit));
      RegBackoff:   prdata = DataW'(backoff_khz);
      RegIdle:      prdata = DataW'(idle_khz);
      default:      prdata = '0;
    endcase
  end

  // evaluation of the registered item
  logic [TimeW-1:0] elapsed;
  logic [KhzW-1:0]  wl_target;
  logic             wl_change;
  logic [KhzW-1:0]  t1;
  logic             backoff_hit;
  logic             restore_hit;

  always_comb begin
    elapsed   = s1.now_ms - adjust_stamp;
    wl_target = target_freq;
    if (s1.load_level >= high_intensity_thr && s1.avg_duration >= DurHigh) begin
      wl_target = MaxKhz;
    end else if (s1.load_level >= med_intensity_thr && s1.avg_duration >= DurMed) begin
      wl_target = MedKhz;
    end else if (s1.load_level <= low_intensity_thr && s1.avg_duration < DurShort) begin
      wl_target = idle_khz;
    end else if (s1.load_level <= ModerateIdleInten) begin
      wl_target = idle_khz;
    end
    wl_change = (s1.sample_count != '0) && (elapsed > TimeW'(hold_off))
                && (wl_target != target_freq);

    target_freq_next     = target_freq;
    adjust_stamp_next    = adjust_stamp;
    recorded_target_next = recorded_target;
    adjust_counter_next  = adjust_counter;
    idle_counter_next    = idle_counter;
    idle_stamp_next      = idle_stamp;

    if (wl_change) begin
      target_freq_next     = wl_target;
      adjust_stamp_next    = s1.now_ms;
      recorded_target_next = wl_target;
      adjust_counter_next  = adjust_counter + CntW'(1);
      if (wl_target == idle_khz) begin
        idle_stamp_next   = s1.now_ms;
        idle_counter_next = idle_counter + CntW'(1);
      end
    end

    t1 = target_freq_next;
    backoff_hit = ($signed(s1.temperature) > hot_limit) && (t1 > backoff_khz);
    restore_hit = ($signed(s1.temperature) < cool_limit) && (t1 < MaxKhz);
    if (backoff_hit) begin
      target_freq_next     = backoff_khz;
      adjust_stamp_next    = s1.now_ms;
      recorded_target_next = backoff_khz;
      adjust_counter_next  = adjust_counter_next + CntW'(1);
    end else if (restore_hit) begin
      target_freq_next = MaxKhz;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_off           <= 16'd2000;
      high_intensity_thr <= IntenW'(1280);
      med_intensity_thr  <= IntenW'(960);
      low_intensity_thr  <= IntenW'(320);
      hot_limit          <= TempW'(1152);
      cool_limit         <= TempW'(1040);
      backoff_khz        <= KhzW'(200000);
      idle_khz           <= KhzW'(100000);
    end else if (cfg_write) begin
      unique case (reg_index)
        RegCooldown:  hold_off           <= pwdata[15:0];
        RegHighInten: high_intensity_thr <= pwdata[IntenW-1:0];
        RegMedInten:  med_intensity_thr  <= pwdata[IntenW-1:0];
        RegLowInten:  low_intensity_thr  <= pwdata[IntenW-1:0];
        RegHotLimit:  hot_limit          <= $signed(pwdata[TempW-1:0]);
        RegCoolLimit: cool_limit         <= $signed(pwdata[TempW-1:0]);
        RegBackoff:   backoff_khz        <= pwdata[KhzW-1:0];
        RegIdle:      idle_khz           <= pwdata[KhzW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid        <= 1'b0;
      result_valid    <= 1'b0;
      target_freq     <= MaxKhz;
      adjust_stamp    <= '0;
      recorded_target <= '0;
      adjust_counter  <= '0;
      idle_counter    <= '0;
      idle_stamp      <= '0;
    end else begin
      if (!tick_stall) begin
        s1_valid <= tick_valid;
      end
      if (advance) begin
        result_valid <= s1_valid;
      end
      // state moves only as an item leaves the input register
      if (advance && s1_valid) begin
        target_freq     <= target_freq_next;
        adjust_stamp    <= adjust_stamp_next;
        recorded_target <= recorded_target_next;
        adjust_counter  <= adjust_counter_next;
        idle_counter    <= idle_counter_next;
        idle_stamp      <= idle_stamp_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tick_valid && !tick_stall) begin
      s1 <= tick;
    end
    if (advance && s1_valid) begin
      result.goal_khz          <= target_freq_next;
      result.ramp_request      <= (target_freq_next != s1.running_khz);
      result.adjust_total      <= adjust_counter_next;
      result.idle_switch_total <= idle_counter_next;
      result.last_set_khz      <= recorded_target_next;
      result.last_adjust_time  <= adjust_stamp_next;
      result.last_idle_time    <= idle_stamp_next;
    end
  end

endmodule

`default_nettype wire

>>> tb/governor_checker.sv
// ----------------------------------------------------------------------------
// governor_checker
// Watches the tick, result and APB channels of the frequency governor,
// predicts each result item from its own copy of the tuning registers and
// governor state, and compares every field against the block's output.
// ----------------------------------------------------------------------------
`default_nettype none

module governor_checker (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic                      pready,
  input  wire logic [pfg_pkg::AddrW-1:0] paddr,
  input  wire logic [pfg_pkg::DataW-1:0] pwdata,
  input  wire logic                      tick_valid,
  input  wire logic                      tick_stall,
  input  wire pfg_pkg::tick_t            tick,
  input  wire logic                      result_valid,
  input  wire logic                      result_stall,
  input  wire pfg_pkg::result_t          result,
  output int                             mismatches,
  output int                             reports_due
);
  import pfg_pkg::*;

  localparam logic [KhzW-1:0] MaxKhz = KhzW'(DefMaxFreqKhz);
  localparam logic [KhzW-1:0] MedKhz =
    (DefMaxFreqKhz > DefMedStepKhz) ? KhzW'(DefMedStepKhz) : MaxKhz;

  // tuning registers
  logic [15:0]             cooldown;
  logic [IntenW-1:0]       thr_high;
  logic [IntenW-1:0]       thr_med;
  logic [IntenW-1:0]       thr_low;
  logic signed [TempW-1:0] hot_lim;
  logic signed [TempW-1:0] cool_lim;
  logic [KhzW-1:0]         backoff;
  logic [KhzW-1:0]         idle;

  // governor state
  logic [KhzW-1:0]  target;
  logic [KhzW-1:0]  last_set;
  logic [TimeW-1:0] adj_stamp;
  logic [TimeW-1:0] idle_stamp;
  logic [CntW-1:0]  adj_cnt;
  logic [CntW-1:0]  idle_cnt;

  result_t pending_reports[$];
  result_t want;

  function automatic result_t govern_tick(tick_t t);
    logic [TimeW-1:0] elapsed;
    logic [KhzW-1:0]  next_goal;
    result_t          r;
    elapsed = t.now_ms - adj_stamp;
    if (t.sample_count != '0 && elapsed > {16'd0, cooldown}) begin
      next_goal = target;
      if (t.load_level >= thr_high && t.avg_duration >= DurW'(DefDurHighMs)) begin
        next_goal = MaxKhz;
      end else if (t.load_level >= thr_med &&
                   t.avg_duration >= DurW'(DefDurMedMs)) begin
        next_goal = MedKhz;
      end else if (t.load_level <= thr_low &&
                   t.avg_duration < DurW'(DefDurShortMs)) begin
        next_goal = idle;
      end else if (t.load_level <= ModerateIdleInten) begin
        next_goal = idle;
      end
      if (next_goal != target) begin
        target    = next_goal;
        adj_stamp = t.now_ms;
        last_set  = next_goal;
        adj_cnt++;
        if (next_goal == idle) begin
          idle_stamp = t.now_ms;
          idle_cnt++;
        end
      end
    end
    // backoff takes priority over restore, even with crossed limits
    if ($signed(t.temperature) > hot_lim && target > backoff) begin
      target    = backoff;
      adj_stamp = t.now_ms;
      last_set  = backoff;
      adj_cnt++;
    end else if ($signed(t.temperature) < cool_lim && target < MaxKhz) begin
      target = MaxKhz;
    end
    r.goal_khz          = target;
    r.ramp_request      = (target != t.running_khz);
    r.adjust_total      = adj_cnt;
    r.idle_switch_total = idle_cnt;
    r.last_set_khz      = last_set;
    r.last_adjust_time  = adj_stamp;
    r.last_idle_time    = idle_stamp;
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] expected, logic [31:0] actual);
    if (actual !== expected) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, expected, actual);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cooldown   = 16'd2000;
      thr_high   = IntenW'(1280);
      thr_med    = IntenW'(960);
      thr_low    = IntenW'(320);
      hot_lim    = TempW'(1152);
      cool_lim   = TempW'(1040);
      backoff    = KhzW'(200000);
      idle       = KhzW'(100000);
      target     = MaxKhz;
      last_set   = '0;
      adj_stamp  = '0;
      idle_stamp = '0;
      adj_cnt    = '0;
      idle_cnt   = '0;
      mismatches = 0;
      pending_reports.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[AddrW-1:2])
          RegCooldown:  cooldown = pwdata[15:0];
          RegHighInten: thr_high = pwdata[IntenW-1:0];
          RegMedInten:  thr_med  = pwdata[IntenW-1:0];
          RegLowInten:  thr_low  = pwdata[IntenW-1:0];
          RegHotLimit:  hot_lim  = pwdata[TempW-1:0];
          RegCoolLimit: cool_lim = pwdata[TempW-1:0];
          RegBackoff:   backoff  = pwdata[KhzW-1:0];
          RegIdle:      idle     = pwdata[KhzW-1:0];
          default: ;
        endcase
      end
      if (result_valid && !result_stall) begin
        if (pending_reports.size() == 0) begin
          $display("%0t: result item with none expected, actual %0h", $time, result);
          mismatches++;
        end else begin
          want = pending_reports.pop_front();
          check_field("goal_khz", 32'(want.goal_khz), 32'(result.goal_khz));
          check_field("ramp_request", 32'(want.ramp_request),
                      32'(result.ramp_request));
          check_field("adjust_total", want.adjust_total, result.adjust_total);
          check_field("idle_switch_total", want.idle_switch_total,
                      result.idle_switch_total);
          check_field("last_set_khz", 32'(want.last_set_khz),
                      32'(result.last_set_khz));
          check_field("last_adjust_time", want.last_adjust_time,
                      result.last_adjust_time);
          check_field("last_idle_time", want.last_idle_time, result.last_idle_time);
        end
      end
      if (tick_valid && !tick_stall) begin
        pending_reports.push_back(govern_tick(tick));
      end
    end
    reports_due = pending_reports.size();
  end

endmodule

`default_nettype wire

>>> tb/tb_perf_frequency_governor_unit.sv
// ----------------------------------------------------------------------------
// tb_perf_frequency_governor_unit
// Drives governor ticks through directed corner cases and random phases
// under several tuning settings, with bursty input and random output stall;
// the checker predicts and compares every result item.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_perf_frequency_governor_unit;
  import pfg_pkg::*;

  localparam int StuckLimit   = 2000;
  localparam int PhaseItems   = 204;
  localparam int PressureHold = 80;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic             tick_valid = 1'b0;
  tick_t            tick = '0;
  logic             result_stall = 1'b0;
  wire [DataW-1:0]  prdata;
  wire              pready;
  wire              tick_stall;
  wire              result_valid;
  result_t          result;
  int               mismatches;
  int               reports_due;

  // shadow of the tuning registers, used to aim the stimulus
  int               cfg_cooldown = 2000;
  int               cfg_high = 1280;
  int               cfg_med = 960;
  int               cfg_low = 320;
  int               cfg_hot = 1152;
  int               cfg_cool = 1040;
  int               cfg_backoff = 200000;
  int               cfg_idle = 100000;

  logic [TimeW-1:0] now_q = '0;
  logic [KhzW-1:0]  seen_target = KhzW'(DefMaxFreqKhz);
  bit               pressure_req = 1'b0;
  int               stuck_cycles = 0;

  perf_frequency_governor_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .tick_valid   (tick_valid),
    .tick_stall   (tick_stall),
    .tick         (tick),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  governor_checker gov_check (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .tick_valid   (tick_valid),
    .tick_stall   (tick_stall),
    .tick         (tick),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .mismatches   (mismatches),
    .reports_due  (reports_due)
  );

  always #5 clk = ~clk;

  // the running clock fed back into running_khz follows the reported target
  always @(posedge clk) begin
    if (result_valid && !result_stall) begin
      seen_target <= result.goal_khz;
    end
  end

  always @(posedge clk) begin
    if (rst || (tick_valid && !tick_stall) || (result_valid && !result_stall) ||
        (psel && penable)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= StuckLimit) begin
      $display("perf_frequency_governor_unit: mismatch");
      $finish;
    end
  end

  // receiver: random stall modes, plus one long hold-off on request
  initial begin
    int mode;
    int seg;
    int hold;
    mode = 0;
    seg  = 0;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
        result_stall <= 1'b1;
      end else if (pressure_req) begin
        pressure_req = 1'b0;
        hold = PressureHold - 1;
        result_stall <= 1'b1;
      end else begin
        if (seg == 0) begin
          mode = $urandom_range(0, 3);
          seg  = $urandom_range(5, 120);
        end
        seg--;
        case (mode)
          0: result_stall <= 1'b0;
          1: result_stall <= ($urandom_range(0, 3) == 0);
          2: result_stall <= ($urandom_range(0, 3) != 0);
          default: result_stall <= ~result_stall;
        endcase
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apply_settings(int cd, int hi, int med, int lo, int hot, int cool,
                                int bo, int idl);
    write_reg(RegCooldown, 32'(cd));
    write_reg(RegHighInten, 32'(hi));
    write_reg(RegMedInten, 32'(med));
    write_reg(RegLowInten, 32'(lo));
    write_reg(RegHotLimit, 32'(hot));
    write_reg(RegCoolLimit, 32'(cool));
    write_reg(RegBackoff, 32'(bo));
    write_reg(RegIdle, 32'(idl));
    cfg_cooldown = cd;
    cfg_high     = hi;
    cfg_med      = med;
    cfg_low      = lo;
    cfg_hot      = hot;
    cfg_cool     = cool;
    cfg_backoff  = bo;
    cfg_idle     = idl;
  endtask

  task automatic send_tick(tick_t t);
    @(negedge clk);
    tick_valid <= 1'b1;
    tick       <= t;
    do @(posedge clk); while (tick_stall);
  endtask

  task automatic pause_sender(int cycles);
    @(negedge clk);
    tick_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic drain();
    pause_sender(1);
    wait (reports_due == 0);
    repeat (4) @(posedge clk);
  endtask

  function automatic tick_t mk_tick(logic [31:0] now, int samples, int inten, int dur,
                                    int temp, int cur);
    tick_t t;
    t.now_ms       = now;
    t.sample_count = 16'(samples);
    t.load_level   = IntenW'(inten);
    t.avg_duration = DurW'(dur);
    t.temperature  = TempW'(temp);
    t.running_khz  = KhzW'(cur);
    return t;
  endfunction

  function automatic tick_t random_tick();
    int    pick;
    int    samples;
    int    inten;
    int    dur;
    int    temp;
    int    cur;
    pick = $urandom_range(0, 15);
    // half the time step past the cooldown so the workload rule keeps firing
    if (pick < 8) now_q += 32'(cfg_cooldown + $urandom_range(1, 300));
    else if (pick < 12) now_q += 32'($urandom_range(0, cfg_cooldown));
    else if (pick < 14) now_q += 32'(cfg_cooldown);
    else now_q += $urandom;
    case ($urandom_range(0, 7))
      0: samples = 0;
      1, 2, 3: samples = $urandom_range(1, 64);
      default: samples = $urandom_range(0, 65535);
    endcase
    case ($urandom_range(0, 7))
      0: inten = cfg_high + $urandom_range(0, 2) - 1;
      1: inten = cfg_med + $urandom_range(0, 2) - 1;
      2: inten = cfg_low + $urandom_range(0, 2) - 1;
      3: inten = 639 + $urandom_range(0, 2);
      4, 5: inten = $urandom_range(0, 1600);
      default: inten = $urandom_range(0, 2047);
    endcase
    case ($urandom_range(0, 5))
      0: dur = DefDurHighMs - 1 + $urandom_range(0, 1);
      1: dur = DefDurMedMs - 1 + $urandom_range(0, 1);
      2: dur = DefDurShortMs - 1 + $urandom_range(0, 1);
      3, 4: dur = $urandom_range(0, 1000);
      default: dur = $urandom_range(0, 65535);
    endcase
    case ($urandom_range(0, 5))
      0, 1: temp = cfg_hot + $urandom_range(0, 40) - 20;
      2, 3: temp = cfg_cool + $urandom_range(0, 40) - 20;
      4: temp = $urandom_range(0, 2640) - 640;
      default: temp = $urandom_range(0, 4095);
    endcase
    case ($urandom_range(0, 7))
      0, 1, 2, 3: cur = int'(seen_target);
      4: cur = cfg_idle;
      5: cur = cfg_backoff;
      6: cur = DefMaxFreqKhz;
      default: cur = $urandom_range(0, 524287);
    endcase
    return mk_tick(now_q, samples, inten, dur, temp, cur);
  endfunction

  task automatic run_random(int count, bit pressure);
    int burst;
    int gap;
    burst = pressure ? 60 : $urandom_range(1, 30);
    // back-to-back items while the receiver holds off
    if (pressure) pressure_req = 1'b1;
    for (int i = 0; i < count; i++) begin
      send_tick(random_tick());
      burst--;
      if (burst == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
        if (gap > 0) pause_sender(gap);
        burst = $urandom_range(1, 40);
      end
    end
    drain();
  endtask

  task automatic run_directed();
    tick_t items[$];
    items.push_back(mk_tick(32'd100, 0, 1600, 600, 1100, 250000));   // no samples
    items.push_back(mk_tick(32'd1000, 5, 960, 300, 1100, 250000));   // inside cooldown
    items.push_back(mk_tick(32'd2000, 5, 960, 300, 1100, 250000));   // exactly cooldown
    items.push_back(mk_tick(32'd2001, 5, 960, 250, 1100, 250000));   // medium tier
    items.push_back(mk_tick(32'd4002, 1, 1280, 500, 1100, 230000));  // high tier
    items.push_back(mk_tick(32'd6003, 65535, 320, 199, 1100, 250000)); // short light
    items.push_back(mk_tick(32'd8004, 2, 2047, 65535, 1100, 100000));
    items.push_back(mk_tick(32'd10005, 3, 640, 300, 1100, 250000));  // moderate idle
    items.push_back(mk_tick(32'd12006, 3, 641, 199, 1100, 100000));  // no tier
    items.push_back(mk_tick(32'd14007, 3, 0, 0, -2048, 0));          // restore
    items.push_back(mk_tick(32'd14008, 0, 0, 0, 1153, 250000));      // backoff
    items.push_back(mk_tick(32'd14009, 0, 0, 0, 1152, 200000));
    items.push_back(mk_tick(32'd14010, 0, 0, 0, 1039, 524287));
    items.push_back(mk_tick(32'd14011, 0, 0, 0, 2047, 250000));
    items.push_back(mk_tick(32'hFFFF_F000, 4, 1600, 1000, 1100, 200000));
    items.push_back(mk_tick(32'h0000_0100, 4, 960, 250, 1100, 250000)); // across wrap
    items.push_back(mk_tick(32'h0000_0200, 4, 100, 100, 1100, 230000));
    items.push_back(mk_tick(32'hFFFF_FFFF, 4, 1279, 499, 1100, 230000));
    items.push_back(mk_tick(32'h0000_1000, 7, 959, 1000, 1100, 230000));
    items.push_back(mk_tick(32'h0000_2000, 7, 1280, 499, 1100, 230000));
    items.push_back(mk_tick(32'h0000_3000, 9, 0, 65535, 1040, 230000));
    items.push_back(mk_tick(32'h0000_4000, 9, 2047, 0, 1041, 0));
    foreach (items[i]) send_tick(items[i]);
    now_q = 32'h0001_0000;
    drain();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    repeat (3) @(negedge clk);
    run_directed();
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: ;  // reset tuning
        1: apply_settings(0, 0, 0, 0, -640, -640, 0, 0);
        2: apply_settings(65535, 1600, 1600, 1600, 2000, 2000, 500000, 500000);
        // crossed limits, medium threshold above high, idle on the medium step
        3: apply_settings(1500, 800, 1200, 400, -640, 2000, DefMaxFreqKhz,
                          DefMedStepKhz);
        4: apply_settings(300, 2047, 2047, 2047, 2047, -2048, 524287, DefMaxFreqKhz);
        5: apply_settings(2000, 1280, 960, 320, 1152, 1040, 200000, 200000);
        default: apply_settings($urandom_range(0, 5000), $urandom_range(0, 1600),
                                $urandom_range(0, 1600), $urandom_range(0, 1600),
                                $urandom_range(0, 2640) - 640,
                                $urandom_range(0, 2640) - 640,
                                $urandom_range(0, 500000), $urandom_range(0, 500000));
      endcase
      run_random(PhaseItems, ph == 0);
    end
    repeat (8) @(posedge clk);
    if (mismatches == 0 && reports_due == 0) begin
      $display("perf_frequency_governor_unit: match");
    end else begin
      $display("perf_frequency_governor_unit: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
